@@ rtl/mpsr_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor PWM soft ramp: shared definitions
// Request codes, register indexes, phase encoding and reset values.
// ----------------------------------------------------------------------------
package mpsr_pkg;

  typedef enum logic [2:0] {
    REQ_TICK       = 3'd0,
    REQ_SLOW_START = 3'd1,
    REQ_SLOW_STOP  = 3'd2,
    REQ_IMM_STOP   = 3'd3,
    REQ_SET_CEIL   = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    CFG_MOTOR_KIND    = 3'd0,
    CFG_FULL_DUTY     = 3'd1,
    CFG_START_DUTY    = 3'd2,
    CFG_RISE_STEP     = 3'd3,
    CFG_FALL_STEP     = 3'd4,
    CFG_RAMP_INTERVAL = 3'd5
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PH_WAIT      = 5'b00001,
    PH_RAMP_UP   = 5'b00010,
    PH_RAMP_DOWN = 5'b00100,
    PH_SETTLE    = 5'b01000,
    PH_DONE      = 5'b10000
  } phase_e;

  localparam logic [2:0] PH_CODE_WAIT      = 3'd0;
  localparam logic [2:0] PH_CODE_RAMP_UP   = 3'd1;
  localparam logic [2:0] PH_CODE_RAMP_DOWN = 3'd2;
  localparam logic [2:0] PH_CODE_SETTLE    = 3'd3;
  localparam logic [2:0] PH_CODE_DONE      = 3'd4;

  localparam logic [15:0] SETTLE_TICKS = 16'd10;

  localparam logic        RST_MOTOR_KIND    = 1'b0;
  localparam logic [7:0]  RST_FULL_DUTY     = 8'd100;
  localparam logic [7:0]  RST_START_DUTY    = 8'd30;
  localparam logic [7:0]  RST_RISE_STEP     = 8'd2;
  localparam logic [7:0]  RST_FALL_STEP     = 8'd6;
  localparam logic [15:0] RST_RAMP_INTERVAL = 16'd10;

  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] code;
    case (ph)
      PH_WAIT:      code = PH_CODE_WAIT;
      PH_RAMP_UP:   code = PH_CODE_RAMP_UP;
      PH_RAMP_DOWN: code = PH_CODE_RAMP_DOWN;
      PH_SETTLE:    code = PH_CODE_SETTLE;
      PH_DONE:      code = PH_CODE_DONE;
      default:      code = PH_CODE_WAIT;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/mpsr_if.sv @@
// ----------------------------------------------------------------------------
// Motor PWM soft ramp: channel interfaces
// Request, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mpsr_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic       relay_active;
  logic       slow_mode;
  logic [7:0] ceiling_value;

  modport source (output valid, req_type, relay_active, slow_mode, ceiling_value,
                  input ready);
  modport sink   (input valid, req_type, relay_active, slow_mode, ceiling_value,
                  output ready);
endinterface

interface mpsr_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty;
  logic [2:0] phase;
  logic       stop_request;

  modport source (output valid, duty, phase, stop_request, input ready);
  modport sink   (input valid, duty, phase, stop_request, output ready);
endinterface

interface mpsr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/motor_pwm_soft_ramp.sv @@
// ----------------------------------------------------------------------------
// Motor PWM soft ramp
// Per-motor PWM duty sequencer with soft start and soft stop.
//
// Usage:
//   req_i carries one item per handshake: a tick or a command, with the
//   relay-active and slow-mode flags and a ceiling value for set ceiling.
//   res_o returns exactly one item per request: duty, phase and the stop
//   request raised by the done phase.
//   cfg_i writes the six ramp registers by index and is always ready; the user
//   must write it only while no request is in flight, which is not enforced.
//   The result is registered and appears in the cycle after the request is
//   taken. One item is taken every cycle unless the receiver stalls: the
//   phase update is a short compare-and-add chain ahead of the result
//   register, and a new request is taken while it empties in the same cycle.
//   When the receiver stalls, the result register holds and req_i.ready
//   drops until the result is taken.
//   Reset clears the phase, tick count and duty, loads the registers with
//   their default values and sets the ceiling to the default full duty.
// ----------------------------------------------------------------------------
module motor_pwm_soft_ramp (
  input  logic         clk_i,
  input  logic         rst_ni,
  mpsr_req_if.sink     req_i,
  mpsr_res_if.source   res_o,
  mpsr_cfg_if.sink     cfg_i
);
  import mpsr_pkg::*;

  logic        motor_kind_q;
  logic [7:0]  full_duty_q;
  logic [7:0]  start_duty_q;
  logic [7:0]  rise_step_q;
  logic [7:0]  fall_step_q;
  logic [15:0] ramp_interval_q;

  phase_e      phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  duty_q, duty_d;
  logic [7:0]  ceil_q, ceil_d;
  logic        stop_d;

  logic        res_valid_q, res_valid_d;
  logic [7:0]  res_duty_q;
  logic [2:0]  res_phase_q;
  logic        res_stop_q;

  logic        req_accept;
  logic        cfg_accept;
  logic [8:0]  rise_sum;

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  assign req_i.ready = !res_valid_q || res_o.ready;
  assign req_accept  = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_accept  = cfg_i.valid && cfg_i.ready;

  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    duty_d   = duty_q;
    ceil_d   = ceil_q;
    stop_d   = 1'b0;
    rise_sum = 9'd0;
    case (req_e'(req_i.req_type))
      REQ_TICK: begin
        if (!req_i.relay_active) begin
          phase_d = PH_WAIT;
          tick_d  = 16'd0;
          duty_d  = 8'd0;
        end else begin
          if (phase_d == PH_WAIT) begin
            tick_d = sat_inc(tick_d);
            if (tick_d >= SETTLE_TICKS) begin
              phase_d = PH_RAMP_UP;
              tick_d  = 16'd0;
              duty_d  = motor_kind_q ? start_duty_q : ceil_q;
            end else begin
              duty_d = 8'd0;
            end
          end
          if (phase_d == PH_RAMP_UP) begin
            ceil_d = req_i.slow_mode ? (full_duty_q >> 1) : full_duty_q;
            if (!motor_kind_q && !req_i.slow_mode) begin
              duty_d = ceil_d;
            end else begin
              tick_d = sat_inc(tick_d);
              if (tick_d >= ramp_interval_q) begin
                rise_sum = {1'b0, duty_d} + {1'b0, rise_step_q};
                tick_d   = 16'd0;
                duty_d   = (rise_sum >= {1'b0, ceil_d}) ? ceil_d : rise_sum[7:0];
              end
            end
          end
          if (phase_d == PH_RAMP_DOWN) begin
            tick_d = sat_inc(tick_d);
            if (tick_d >= ramp_interval_q) begin
              tick_d = 16'd0;
              if (duty_d >= start_duty_q) begin
                duty_d = (duty_d > fall_step_q) ? duty_d - fall_step_q : 8'd0;
              end else begin
                duty_d  = 8'd0;
                phase_d = PH_SETTLE;
              end
            end
          end
          if (phase_d == PH_SETTLE) begin
            duty_d = 8'd0;
            tick_d = sat_inc(tick_d);
            if (tick_d >= SETTLE_TICKS) begin
              phase_d = PH_DONE;
              tick_d  = 16'd0;
            end
          end
          if (phase_d == PH_DONE) begin
            duty_d = 8'd0;
            stop_d = 1'b1;
          end
        end
      end
      REQ_SLOW_START: begin
        if (!req_i.relay_active) begin
          phase_d = PH_WAIT;
          tick_d  = 16'd0;
        end
      end
      REQ_SLOW_STOP: begin
        if (req_i.relay_active && (phase_q == PH_WAIT || phase_q == PH_RAMP_UP)) begin
          phase_d = PH_RAMP_DOWN;
          tick_d  = 16'd0;
        end
      end
      REQ_IMM_STOP: begin
        if (!req_i.relay_active) begin
          phase_d = PH_DONE;
        end else if (phase_q == PH_WAIT || phase_q == PH_RAMP_UP ||
                     phase_q == PH_RAMP_DOWN) begin
          phase_d = PH_SETTLE;
          tick_d  = 16'd0;
        end
      end
      REQ_SET_CEIL: begin
        ceil_d = req_i.ceiling_value;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (req_accept) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_kind_q    <= RST_MOTOR_KIND;
      full_duty_q     <= RST_FULL_DUTY;
      start_duty_q    <= RST_START_DUTY;
      rise_step_q     <= RST_RISE_STEP;
      fall_step_q     <= RST_FALL_STEP;
      ramp_interval_q <= RST_RAMP_INTERVAL;
    end else if (cfg_accept) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_MOTOR_KIND:    motor_kind_q    <= cfg_i.data[0];
        CFG_FULL_DUTY:     full_duty_q     <= cfg_i.data[7:0];
        CFG_START_DUTY:    start_duty_q    <= cfg_i.data[7:0];
        CFG_RISE_STEP:     rise_step_q     <= cfg_i.data[7:0];
        CFG_FALL_STEP:     fall_step_q     <= cfg_i.data[7:0];
        CFG_RAMP_INTERVAL: ramp_interval_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      tick_q      <= 16'd0;
      duty_q      <= 8'd0;
      ceil_q      <= RST_FULL_DUTY;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (req_accept) begin
        phase_q <= phase_d;
        tick_q  <= tick_d;
        duty_q  <= duty_d;
        ceil_q  <= ceil_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      res_duty_q  <= duty_d;
      res_phase_q <= phase_code(phase_d);
      res_stop_q  <= stop_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.duty         = res_duty_q;
  assign res_o.phase        = res_phase_q;
  assign res_o.stop_request = res_stop_q;

  a_stop_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.stop_request |-> res_o.phase == PH_CODE_DONE)
    else $error("stop request outside done phase");

  a_stop_zero_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.stop_request |-> res_o.duty == 8'd0)
    else $error("stop request with non-zero duty");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |=> res_o.valid)
    else $error("accepted item produced no result");

  a_empty_takes_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_o.valid |-> req_i.ready)
    else $error("request stalled with empty result register");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WAIT || phase_q == PH_SETTLE) |-> tick_q < SETTLE_TICKS)
    else $error("tick count past settle limit");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor PWM soft ramp testbench
// Drives ticks and commands through the request channel, predicts duty,
// phase and stop request for every accepted item, and compares each result
// in order. Runs over several register settings, extremes included, with
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import mpsr_pkg::*;

  localparam int          QUIET_LIMIT     = 2000;
  localparam int          ITEMS_PER_PHASE = 90;
  localparam logic [2:0]  REQ_SPARE_5     = 3'd5;
  localparam logic [2:0]  REQ_SPARE_6     = 3'd6;
  localparam logic [2:0]  REQ_SPARE_7     = 3'd7;

  typedef struct packed {
    logic [2:0] req_type;
    logic       relay;
    logic       slow;
    logic [7:0] ceil;
  } ramp_req_t;

  typedef struct packed {
    logic [7:0] duty;
    logic [2:0] phase;
    logic       stop;
  } ramp_res_t;

  logic clk;
  logic rst_n;

  mpsr_req_if req_ch ();
  mpsr_res_if res_ch ();
  mpsr_cfg_if cfg_ch ();

  motor_pwm_soft_ramp u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  ramp_req_t   cmd_backlog[$];
  ramp_res_t   predicted_outputs[$];
  int          queued_items;
  int          mismatches;
  int          quiet_cycles;
  int          cfg_writes;
  int          src_idle_pct;
  int          rcv_stall_pct;
  logic        req_taken;

  logic        m_kind;
  logic [7:0]  m_full;
  logic [7:0]  m_start;
  logic [7:0]  m_rise;
  logic [7:0]  m_fall;
  logic [15:0] m_interval;
  logic [2:0]  m_phase;
  logic [15:0] m_ticks;
  logic [7:0]  m_duty;
  logic [7:0]  m_ceiling;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void advance_ticks();
    if (m_ticks != 16'hFFFF) m_ticks = m_ticks + 16'd1;
  endfunction

  function automatic ramp_res_t step_ramp(ramp_req_t it);
    ramp_res_t  r;
    logic       stop;
    logic [8:0] sum;
    stop = 1'b0;
    case (it.req_type)
      REQ_TICK: begin
        if (!it.relay) begin
          m_ticks = '0;
          m_phase = PH_CODE_WAIT;
          m_duty  = '0;
        end else begin
          if (m_phase == PH_CODE_WAIT) begin
            advance_ticks();
            if (m_ticks >= SETTLE_TICKS) begin
              m_phase = PH_CODE_RAMP_UP;
              m_ticks = '0;
              m_duty  = m_kind ? m_start : m_ceiling;
            end else begin
              m_duty = '0;
            end
          end
          if (m_phase == PH_CODE_RAMP_UP) begin
            m_ceiling = it.slow ? (m_full >> 1) : m_full;
            if (!m_kind && !it.slow) begin
              m_duty = m_ceiling;
            end else begin
              advance_ticks();
              if (m_ticks >= m_interval) begin
                sum     = {1'b0, m_duty} + {1'b0, m_rise};
                m_ticks = '0;
                m_duty  = (sum >= {1'b0, m_ceiling}) ? m_ceiling : sum[7:0];
              end
            end
          end
          if (m_phase == PH_CODE_RAMP_DOWN) begin
            advance_ticks();
            if (m_ticks >= m_interval) begin
              m_ticks = '0;
              if (m_duty >= m_start) begin
                m_duty = (m_duty > m_fall) ? m_duty - m_fall : 8'd0;
              end else begin
                m_duty  = '0;
                m_phase = PH_CODE_SETTLE;
              end
            end
          end
          if (m_phase == PH_CODE_SETTLE) begin
            m_duty = '0;
            advance_ticks();
            if (m_ticks >= SETTLE_TICKS) begin
              m_phase = PH_CODE_DONE;
              m_ticks = '0;
            end
          end
          if (m_phase == PH_CODE_DONE) begin
            m_duty = '0;
            stop   = 1'b1;
          end
        end
      end
      REQ_SLOW_START: begin
        if (!it.relay) begin
          m_phase = PH_CODE_WAIT;
          m_ticks = '0;
        end
      end
      REQ_SLOW_STOP: begin
        if (it.relay && m_phase < PH_CODE_RAMP_DOWN) begin
          m_phase = PH_CODE_RAMP_DOWN;
          m_ticks = '0;
        end
      end
      REQ_IMM_STOP: begin
        if (it.relay) begin
          if (m_phase < PH_CODE_SETTLE) begin
            m_phase = PH_CODE_SETTLE;
            m_ticks = '0;
          end
        end else begin
          m_phase = PH_CODE_DONE;
        end
      end
      REQ_SET_CEIL: m_ceiling = it.ceil;
      default: ;
    endcase
    r.duty  = m_duty;
    r.phase = m_phase;
    r.stop  = stop;
    return r;
  endfunction

  function automatic void queue_req(logic [2:0] kind, logic relay, logic slow,
                                    logic [7:0] ceil);
    ramp_req_t it;
    it.req_type = kind;
    it.relay    = relay;
    it.slow     = slow;
    it.ceil     = ceil;
    cmd_backlog.push_back(it);
    queued_items++;
  endfunction

  // one start-to-stop sequence with random content, or a burst of noise
  function automatic void add_episode();
    int         k;
    int         how;
    logic       slow;
    logic [2:0] stop_kind;
    if ($urandom_range(9) == 0) begin
      k = $urandom_range(3, 8);
      repeat (k) queue_req(3'($urandom_range(7)), 1'($urandom_range(1)),
                           1'($urandom_range(1)), 8'($urandom_range(255)));
      return;
    end
    slow = ($urandom_range(3) == 0);
    queue_req(REQ_SLOW_START, 1'b0, slow, 8'($urandom_range(255)));
    if ($urandom_range(3) == 0) queue_req(REQ_SET_CEIL, 1'($urandom_range(1)), slow,
                                          8'($urandom_range(255)));
    k = $urandom_range(10, 60);
    repeat (k) begin
      if ($urandom_range(29) == 0) slow = ~slow;
      if ($urandom_range(24) == 0)
        queue_req(3'($urandom_range(1, 7)), 1'($urandom_range(1)), slow,
                  8'($urandom_range(255)));
      queue_req(REQ_TICK, $urandom_range(49) != 0, slow, 8'($urandom_range(255)));
    end
    how = $urandom_range(2);
    stop_kind = (how == 1) ? REQ_IMM_STOP : REQ_SLOW_STOP;
    queue_req(stop_kind, 1'b1, slow, 8'($urandom_range(255)));
    k = $urandom_range(5, 120);
    repeat (k) begin
      if (how == 2 && $urandom_range(39) == 0)
        queue_req(REQ_IMM_STOP, 1'b1, slow, 8'($urandom_range(255)));
      queue_req(REQ_TICK, $urandom_range(79) != 0, slow, 8'($urandom_range(255)));
    end
    if ($urandom_range(1) == 0) begin
      queue_req(REQ_IMM_STOP, 1'b0, slow, 8'($urandom_range(255)));
      queue_req(REQ_TICK, 1'b1, slow, 8'($urandom_range(255)));
    end
    queue_req(REQ_TICK, 1'b0, slow, 8'($urandom_range(255)));
  endfunction

  // driver
  always @(negedge clk) begin
    ramp_req_t it;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        it = cmd_backlog.pop_front();
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= it.req_type;
        req_ch.relay_active  <= it.relay;
        req_ch.slow_mode     <= it.slow;
        req_ch.ceiling_value <= it.ceil;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    ramp_res_t got;
    ramp_res_t want;
    ramp_req_t it;
    logic      fired;
    fired = 1'b0;
    if (res_ch.valid && res_ch.ready) begin
      fired     = 1'b1;
      got.duty  = res_ch.duty;
      got.phase = res_ch.phase;
      got.stop  = res_ch.stop_request;
      if (predicted_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: duty %0d phase %0d stop %0b",
                   got.duty, got.phase, got.stop);
      end else begin
        want = predicted_outputs.pop_front();
        if (got.duty != want.duty || got.phase != want.phase || got.stop != want.stop) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected duty %0d phase %0d stop %0b,",
                      " got duty %0d phase %0d stop %0b"},
                     want.duty, want.phase, want.stop, got.duty, got.phase, got.stop);
        end
      end
    end
    if (cfg_ch.valid && cfg_ch.ready) begin
      fired = 1'b1;
      cfg_writes++;
      case (cfg_idx_e'(cfg_ch.index))
        CFG_MOTOR_KIND:    m_kind     = cfg_ch.data[0];
        CFG_FULL_DUTY:     m_full     = cfg_ch.data[7:0];
        CFG_START_DUTY:    m_start    = cfg_ch.data[7:0];
        CFG_RISE_STEP:     m_rise     = cfg_ch.data[7:0];
        CFG_FALL_STEP:     m_fall     = cfg_ch.data[7:0];
        CFG_RAMP_INTERVAL: m_interval = cfg_ch.data;
        default: ;
      endcase
    end
    if (req_ch.valid && req_ch.ready) begin
      fired       = 1'b1;
      it.req_type = req_ch.req_type;
      it.relay    = req_ch.relay_active;
      it.slow     = req_ch.slow_mode;
      it.ceil     = req_ch.ceiling_value;
      predicted_outputs.push_back(step_ramp(it));
    end
    req_taken <= req_ch.valid && req_ch.ready;
    quiet_cycles = fired ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic drain();
    @(posedge clk);
    #1;
    while (cmd_backlog.size() != 0 || req_ch.valid || predicted_outputs.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    int seen;
    @(negedge clk);
    seen = cfg_writes;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do begin
      @(posedge clk);
      #1;
    end while (cfg_writes == seen);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure(logic kind, logic [7:0] full, logic [7:0] start,
                           logic [7:0] rise, logic [7:0] fall, logic [15:0] interval);
    write_reg(CFG_MOTOR_KIND, {15'd0, kind});
    write_reg(CFG_FULL_DUTY, {8'd0, full});
    write_reg(CFG_START_DUTY, {8'd0, start});
    write_reg(CFG_RISE_STEP, {8'd0, rise});
    write_reg(CFG_FALL_STEP, {8'd0, fall});
    write_reg(CFG_RAMP_INTERVAL, interval);
  endtask

  initial begin
    int         ph;
    int         goal;
    logic [7:0] full;
    req_ch.valid         = 1'b0;
    req_ch.req_type      = REQ_TICK;
    req_ch.relay_active  = 1'b0;
    req_ch.slow_mode     = 1'b0;
    req_ch.ceiling_value = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = CFG_MOTOR_KIND;
    cfg_ch.data          = '0;
    res_ch.ready         = 1'b0;
    req_taken            = 1'b0;
    queued_items         = 0;
    mismatches           = 0;
    quiet_cycles         = 0;
    cfg_writes           = 0;
    src_idle_pct         = 0;
    rcv_stall_pct        = 0;
    m_kind               = RST_MOTOR_KIND;
    m_full               = RST_FULL_DUTY;
    m_start              = RST_START_DUTY;
    m_rise               = RST_RISE_STEP;
    m_fall               = RST_FALL_STEP;
    m_interval           = RST_RAMP_INTERVAL;
    m_phase              = PH_CODE_WAIT;
    m_ticks              = '0;
    m_duty               = '0;
    m_ceiling            = RST_FULL_DUTY;
    rst_n                = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    queue_req(REQ_SET_CEIL, 1'b0, 1'b0, 8'hFF);
    queue_req(REQ_SET_CEIL, 1'b1, 1'b1, 8'h00);
    queue_req(REQ_TICK, 1'b0, 1'b0, 8'h5A);
    repeat (10) queue_req(REQ_TICK, 1'b1, 1'b0, 8'hA5);
    queue_req(REQ_SLOW_START, 1'b1, 1'b0, 8'h00);
    queue_req(REQ_SLOW_STOP, 1'b1, 1'b1, 8'hFF);
    queue_req(REQ_TICK, 1'b1, 1'b0, 8'h00);
    queue_req(REQ_IMM_STOP, 1'b1, 1'b0, 8'h00);
    queue_req(REQ_SLOW_STOP, 1'b1, 1'b0, 8'h00);
    queue_req(REQ_IMM_STOP, 1'b0, 1'b0, 8'h00);
    queue_req(REQ_TICK, 1'b1, 1'b1, 8'hFF);
    queue_req(REQ_SPARE_5, 1'b1, 1'b0, 8'h0F);
    queue_req(REQ_SPARE_6, 1'b0, 1'b1, 8'hF0);
    queue_req(REQ_SPARE_7, 1'b1, 1'b1, 8'hFF);
    queue_req(REQ_SLOW_START, 1'b0, 1'b1, 8'h00);
    queue_req(REQ_SLOW_STOP, 1'b0, 1'b0, 8'h00);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: configure(RST_MOTOR_KIND, RST_FULL_DUTY, RST_START_DUTY, RST_RISE_STEP,
                     RST_FALL_STEP, RST_RAMP_INTERVAL);
        1: configure(1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 16'd1);
        2: configure(1'b1, 8'd1, 8'd0, 8'd1, 8'd1, 16'd1);
        3: configure(1'b0, 8'd255, 8'd0, 8'd255, 8'd255, 16'hFFFF);
        default: begin
          full = 8'($urandom_range(1, 255));
          configure(1'($urandom_range(1)), full, 8'($urandom_range(0, full)),
                    8'($urandom_range(1, 40)), 8'($urandom_range(1, 40)),
                    16'($urandom_range(1, 4)));
        end
      endcase
      case (ph % 4)
        0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin src_idle_pct = 65; rcv_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  rcv_stall_pct = 65; end
        default: begin src_idle_pct = 35; rcv_stall_pct = 35; end
      endcase
      goal = queued_items + ITEMS_PER_PHASE;
      while (queued_items < goal) add_episode();
      drain();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ motor_pwm_soft_ramp.f @@
rtl/mpsr_pkg.sv
rtl/mpsr_if.sv
rtl/motor_pwm_soft_ramp.sv
bench/testbench.sv
